// File: rtl/asa_pkg.sv
// Shared types, codes and sizes for the aligned stack arena allocator.
package asa_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 8;
    localparam int META_AW      = $clog2(ARENA_BYTES);
    localparam int OFS_W        = 17;
    localparam int ALIGN_W      = 9;
    localparam int STATUS_W     = 3;

    localparam logic [OFS_W-1:0] ARENA_LIMIT = OFS_W'(ARENA_BYTES);

    // request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ALIGN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_LATEST = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [OFS_W-1:0]   request_bytes;
        logic [ALIGN_W-1:0] align_bytes;
        logic [OFS_W-1:0]   handle_offset;
        logic [OFS_W-1:0]   marker_offset;
    } req_word_t;

    typedef struct packed {
        logic [OFS_W-1:0]    result_offset;
        logic [STATUS_W-1:0] status;
        logic [OFS_W-1:0]    used_after;
    } rsp_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFS_W-1:0]    aligned;
        logic [7:0]          shift_byte;
        logic [OFS_W-1:0]    last_new;
        logic [OFS_W-1:0]    used_new;
    } push_calc_t;

endpackage

// File: rtl/asa_ram.sv
// Generic simple dual-port RAM with registered read data.
module asa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/asa_push_calc.sv
// Push checks and alignment arithmetic for one request.
module asa_push_calc (
    input  asa_pkg::req_word_t       word,
    input  logic [16:0]              used,
    input  logic [16:0]              limit,
    output asa_pkg::push_calc_t      calc
);
    import asa_pkg::*;

    logic [ALIGN_W-1:0] align_m1;
    logic [ALIGN_W-1:0] low_bits;
    logic [18:0]        need;
    logic [17:0]        past;
    logic [17:0]        aligned;
    logic [17:0]        end_ofs;
    logic [9:0]         shift;
    logic               size_zero;
    logic               align_bad;
    logic               no_room;

    assign align_m1  = word.align_bytes - ALIGN_W'(1);
    assign size_zero = (word.request_bytes == '0);
    assign align_bad = (word.align_bytes == '0) || ((word.align_bytes & align_m1) != '0);

    assign need    = 19'(used) + 19'(word.request_bytes) + 19'(word.align_bytes)
                   + 19'(HEADER_BYTES);
    assign no_room = need > 19'(limit);

    // step past the header, then to the next boundary, always at least one byte
    assign past     = 18'(used) + 18'(HEADER_BYTES);
    assign low_bits = past[ALIGN_W-1:0] & align_m1;
    assign shift    = 10'(word.align_bytes) - 10'(low_bits);
    assign aligned  = past + 18'(shift);
    assign end_ofs  = aligned + 18'(word.request_bytes);

    always_comb
    begin
        if (size_zero)
        begin
            calc.status = ST_ZERO_SIZE;
        end
        else if (align_bad)
        begin
            calc.status = ST_BAD_ALIGN;
        end
        else if (no_room)
        begin
            calc.status = ST_NO_MEMORY;
        end
        else
        begin
            calc.status = ST_OK;
        end
        calc.aligned    = aligned[OFS_W-1:0];
        calc.shift_byte = shift[7:0];
        calc.last_new   = word.request_bytes + OFS_W'(shift) + OFS_W'(HEADER_BYTES);
        calc.used_new   = end_ofs[OFS_W-1:0];
    end

endmodule

// File: rtl/aligned_stack_arena_allocator_core.sv
// Top level of the aligned stack arena allocator: sequencer, state and metadata RAM.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request word: push,
//   pop latest, pop to marker or reset. A word is taken when req_valid is high
//   and req_stall is low; req_stall stays high while a request is in work.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one response word per
//   request: aligned offset, status and the used count after the request.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the capacity limit;
//   write it only while no request is in work.
// Sequencing, accept to accept, is set by the byte-wide write and read ports of
//   the metadata RAM: a good push makes eight header byte writes and one shift
//   byte write, a good pop one shift read and three header reads; a pop whose
//   handle is in range but fails the check against the latest allocation stops
//   after the check step, every other request goes straight to the final step.
//   The response appears in the cycle after the final step.
// Reset clears the used count, the last size and the response valid and sets
//   the capacity to 64 KiB; the metadata RAM is not cleared.
// A stalled response holds in the output register; the next request is still
//   taken and worked, and waits at its final step until the register frees.
module aligned_stack_arena_allocator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  asa_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output asa_pkg::rsp_word_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data
);
    import asa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HDR,
        S_SHIFT,
        S_POPCHK,
        S_POPRD,
        S_FIN
    } state_t;

    // control state
    state_t              state_reg,     state_next;
    logic [OFS_W-1:0]    used_reg,      used_next;
    logic [OFS_W-1:0]    last_reg,      last_next;
    logic [OFS_W-1:0]    cap_reg,       cap_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [2:0]          k_reg,         k_next;

    // payload
    req_word_t           item_reg,      item_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [OFS_W-1:0]    offset_reg,    offset_next;
    push_calc_t          calc_reg,      calc_next;
    logic [META_AW-1:0]  raw_reg,       raw_next;
    logic [15:0]         prev_reg,      prev_next;
    rsp_word_t           rsp_reg,       rsp_next;

    // metadata RAM port
    logic                mem_we;
    logic [META_AW-1:0]  mem_waddr;
    logic [7:0]          mem_wdata;
    logic [META_AW-1:0]  mem_raddr;
    logic [7:0]          mem_rdata;

    logic [OFS_W-1:0]    limit;
    push_calc_t          calc;
    logic [OFS_W-1:0]    handle_m1;
    logic                handle_bad;
    logic [ALIGN_W-1:0]  shift9;
    logic [9:0]          back;
    logic [OFS_W-1:0]    raw17;
    logic [OFS_W-1:0]    span;
    logic                pop_bad;
    logic                rsp_free;

    assign limit = (cap_reg < ARENA_LIMIT) ? cap_reg : ARENA_LIMIT;

    asa_push_calc u_calc (
        .word  (item_reg),
        .used  (used_reg),
        .limit (limit),
        .calc  (calc)
    );

    asa_ram #(
        .WIDTH (8),
        .DEPTH (ARENA_BYTES)
    ) u_meta (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // pop handle screening and check against the latest allocation
    assign handle_m1  = item_reg.handle_offset - OFS_W'(1);
    assign handle_bad = (item_reg.handle_offset == '0) || (item_reg.handle_offset > ARENA_LIMIT);
    assign shift9     = (mem_rdata == '0) ? ALIGN_W'(256) : ALIGN_W'(mem_rdata);
    assign back       = 10'(shift9) + 10'(HEADER_BYTES);
    assign raw17      = item_reg.handle_offset - OFS_W'(back);
    assign span       = used_reg - last_reg;
    assign pop_bad    = (item_reg.handle_offset < OFS_W'(back)) || (used_reg < last_reg)
                      || (raw17 != span);

    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        last_next      = last_reg;
        cap_next       = cap_reg;
        k_next         = k_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        calc_next      = calc_reg;
        raw_next       = raw_reg;
        prev_next      = prev_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        mem_we    = 1'b0;
        mem_waddr = used_reg[META_AW-1:0] + META_AW'(k_reg);
        mem_wdata = '0;
        mem_raddr = raw_reg + META_AW'(k_reg);

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                offset_next = '0;
                status_next = ST_OK;
                k_next      = '0;
                mem_raddr   = handle_m1[META_AW-1:0];
                unique case (item_reg.req_type)
                    REQ_PUSH:
                    begin
                        calc_next = calc;
                        if (calc.status != ST_OK)
                        begin
                            status_next = calc.status;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_HDR;
                        end
                    end
                    REQ_POP:
                    begin
                        // the shift byte read is in flight unless the handle is out of range
                        if (handle_bad)
                        begin
                            status_next = ST_NOT_LATEST;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_POPCHK;
                        end
                    end
                    REQ_MARK:
                    begin
                        used_next  = item_reg.marker_offset;
                        state_next = S_FIN;
                    end
                    REQ_CLEAR:
                    begin
                        used_next  = '0;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_HDR:
            begin
                // header holds the previous size, little endian, upper bytes zero
                mem_we = 1'b1;
                case (k_reg)
                    3'd0:    mem_wdata = last_reg[7:0];
                    3'd1:    mem_wdata = last_reg[15:8];
                    3'd2:    mem_wdata = {7'b0, last_reg[16]};
                    default: mem_wdata = '0;
                endcase
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(HEADER_BYTES - 1))
                begin
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = calc_reg.aligned[META_AW-1:0] - META_AW'(1);
                mem_wdata   = calc_reg.shift_byte;
                used_next   = calc_reg.used_new;
                last_next   = calc_reg.last_new;
                offset_next = calc_reg.aligned;
                state_next  = S_FIN;
            end

            S_POPCHK:
            begin
                raw_next = raw17[META_AW-1:0];
                k_next   = '0;
                if (pop_bad)
                begin
                    status_next = ST_NOT_LATEST;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_POPRD;
                end
            end

            S_POPRD:
            begin
                // issue raw+k, collect the byte whose read was issued on the previous pass
                k_next = k_reg + 3'd1;
                case (k_reg)
                    3'd1:    prev_next[7:0]  = mem_rdata;
                    3'd2:    prev_next[15:8] = mem_rdata;
                    default: prev_next       = prev_reg;
                endcase
                if (k_reg == 3'd3)
                begin
                    used_next  = used_reg - last_reg;
                    last_next  = {mem_rdata[0], prev_reg};
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_next.result_offset = offset_reg;
                    rsp_next.status        = status_reg;
                    rsp_next.used_after    = used_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            last_reg      <= '0;
            cap_reg       <= ARENA_LIMIT;
            rsp_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            last_reg      <= last_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
        calc_reg   <= calc_next;
        raw_reg    <= raw_next;
        prev_reg   <= prev_next;
        rsp_reg    <= rsp_next;
    end

endmodule

// File: verif/arena_tb_pkg.sv
// Request predictor and response checker for the stack arena allocator testbench.
package arena_tb_pkg;
    import asa_pkg::*;

    class arena_tracker;
        logic [OFS_W-1:0] capacity;
        logic [OFS_W-1:0] used_cnt;
        logic [OFS_W-1:0] last_size;
        logic [7:0]       meta_mem [ARENA_BYTES];
        bit               meta_seen [ARENA_BYTES];
        int unsigned      live_handles [$];
        rsp_word_t        owed_responses [$];
        int unsigned      mismatches;

        function new();
            capacity   = ARENA_LIMIT;
            used_cnt   = '0;
            last_size  = '0;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [OFS_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return owed_responses.size();
        endfunction

        // False when a pop of this handle would read metadata no push has written.
        function bit pop_is_safe(int unsigned handle);
            int unsigned shift, back, raw;
            if (handle == 0 || handle > ARENA_BYTES)
                return 1'b1;
            if (!meta_seen[handle-1])
                return 1'b0;
            shift = meta_mem[handle-1];
            if (shift == 0)
                shift = 256;
            back = shift + HEADER_BYTES;
            if (handle < back || used_cnt < last_size)
                return 1'b1;
            raw = handle - back;
            if (raw != used_cnt - last_size)
                return 1'b1;
            return meta_seen[raw] && meta_seen[raw+1] && meta_seen[raw+2];
        endfunction

        // Advance the allocator state by one accepted request word and queue its response.
        function void note_request(req_word_t w);
            rsp_word_t   r;
            int unsigned size, align, limit, at, past, aligned, shift, handle, back, raw;
            int          k;
            logic [63:0] hdr;
            r = '0;
            case (w.req_type)
                REQ_PUSH:
                begin
                    size  = w.request_bytes;
                    align = w.align_bytes;
                    limit = (capacity < ARENA_BYTES) ? capacity : ARENA_BYTES;
                    if (size == 0)
                        r.status = ST_ZERO_SIZE;
                    else if (align == 0 || align > 256 || (align & (align - 1)) != 0)
                        r.status = ST_BAD_ALIGN;
                    else if (used_cnt + size + align + HEADER_BYTES > limit)
                        r.status = ST_NO_MEMORY;
                    else
                    begin
                        at  = used_cnt;
                        hdr = 64'(last_size);
                        for (k = 0; k < HEADER_BYTES; k++)
                        begin
                            meta_mem[at+k]  = hdr[8*k +: 8];
                            meta_seen[at+k] = 1'b1;
                        end
                        past    = at + HEADER_BYTES;
                        aligned = (past + align - 1) & ~(align - 1);
                        if (aligned == past)
                            aligned += align;
                        shift = aligned - past;
                        meta_mem[aligned-1]  = 8'(shift);
                        meta_seen[aligned-1] = 1'b1;
                        last_size       = OFS_W'(size + shift + HEADER_BYTES);
                        used_cnt        = OFS_W'(used_cnt + last_size);
                        r.result_offset = OFS_W'(aligned);
                        live_handles.push_back(aligned);
                    end
                end
                REQ_POP:
                begin
                    handle   = w.handle_offset;
                    r.status = ST_NOT_LATEST;
                    if (handle != 0 && handle <= ARENA_BYTES)
                    begin
                        shift = meta_mem[handle-1];
                        if (shift == 0)
                            shift = 256;
                        back = shift + HEADER_BYTES;
                        if (handle >= back && used_cnt >= last_size &&
                            handle - back == used_cnt - last_size)
                        begin
                            raw       = handle - back;
                            r.status  = ST_OK;
                            used_cnt  = used_cnt - last_size;
                            last_size = {meta_mem[raw+2][0], meta_mem[raw+1], meta_mem[raw]};
                            if (live_handles.size() != 0 && live_handles[$] == handle)
                                void'(live_handles.pop_back());
                            else
                                live_handles.delete();
                        end
                    end
                end
                REQ_MARK:
                begin
                    used_cnt = w.marker_offset;
                    live_handles.delete();
                end
                REQ_CLEAR:
                begin
                    used_cnt = '0;
                    live_handles.delete();
                end
            endcase
            r.used_after = used_cnt;
            owed_responses.push_back(r);
        endfunction

        function void compare_field(string field, logic [OFS_W-1:0] want,
                                    logic [OFS_W-1:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        // Compare one accepted response word with the oldest one owed.
        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (owed_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: response with none owed, expected none, actual %0d/%0d/%0d",
                             $time, got.result_offset, got.status, got.used_after);
                return;
            end
            want = owed_responses.pop_front();
            compare_field("result_offset", want.result_offset, got.result_offset);
            compare_field("status", OFS_W'(want.status), OFS_W'(got.status));
            compare_field("used_after", want.used_after, got.used_after);
        endfunction
    endclass

endpackage

// File: verif/tb_top.sv
// Self-checking testbench top for the aligned stack arena allocator core.
module tb_top;
    import asa_pkg::*;
    import arena_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on any channel
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 145;
    localparam int PHASES      = 7;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_word_t        req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_word_t        rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [OFS_W-1:0] cfg_data  = '0;

    arena_tracker tracker     = new();
    int unsigned  idle_cycles = 0;
    bit           calm        = 1'b0;  // when set, neither side inserts gaps or stalls

    aligned_stack_arena_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Check every response word at the edge that moves it, and run the watchdog:
    // end the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                tracker.check_response(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive the response stall: free runs, short stalls and the odd long one.
    initial
    begin : rsp_stall_gen
        int unsigned hold;
        int unsigned roll;
        bit          level;
        hold  = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 30);
                end
                else if (roll < 90)
                begin
                    level = 1'b1;
                    hold  = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b1;
                    hold  = $urandom_range(10, 40);
                end
            end
            hold--;
            rsp_stall <= calm ? 1'b0 : level;
        end
    end

    // Idle cycles before the next request word: mostly none, some short, a few long.
    function automatic int unsigned sender_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_word_t make_word(logic [1:0] kind, int unsigned size,
                                            int unsigned align, int unsigned handle,
                                            int unsigned mark);
        req_word_t w;
        w.req_type      = kind;
        w.request_bytes = OFS_W'(size);
        w.align_bytes   = ALIGN_W'(align);
        w.handle_offset = OFS_W'(handle);
        w.marker_offset = OFS_W'(mark);
        return w;
    endfunction

    // Build the next random request word. Most traffic is push/pop of the live
    // stack so allocations nest deep; the rest is bad sizes, bad alignments,
    // stale handles, markers and clears. Fields a request ignores stay random.
    function automatic req_word_t next_request();
        req_word_t   w;
        int unsigned roll, pick, depth;
        w.request_bytes = OFS_W'($urandom);
        w.align_bytes   = ALIGN_W'($urandom);
        w.handle_offset = OFS_W'($urandom);
        w.marker_offset = OFS_W'($urandom);
        depth = tracker.live_handles.size();
        roll  = $urandom_range(0, 99);
        if (roll < 48)
        begin
            w.req_type = REQ_PUSH;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w.request_bytes = '0;
            else if (pick == 1)
                w.request_bytes = OFS_W'($urandom_range(4096, ARENA_BYTES));
            else if (pick > 3)
                w.request_bytes = OFS_W'($urandom_range(1, 256));
            // keep a raw random alignment now and then, else a power of two
            if ($urandom_range(0, 9) != 0)
                w.align_bytes = ALIGN_W'(1 << $urandom_range(0, 8));
        end
        else if (roll < 88)
        begin
            w.req_type = REQ_POP;
            pick = $urandom_range(0, 9);
            if (depth != 0 && pick < 7)
                w.handle_offset = OFS_W'(tracker.live_handles[depth-1]);
            else if (depth != 0 && pick == 7)
                w.handle_offset = OFS_W'(tracker.live_handles[$urandom_range(0, depth-1)]);
            else if (pick == 8)
                w.handle_offset = OFS_W'($urandom_range(0, ARENA_BYTES));
            // drop handles whose pop would read never-written metadata
            if (!tracker.pop_is_safe(w.handle_offset))
                w.handle_offset = '0;
        end
        else if (roll < 94)
        begin
            w.req_type = REQ_MARK;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                w.marker_offset = OFS_W'($urandom_range(0, tracker.used_cnt));
            else if (pick < 8)
                w.marker_offset = OFS_W'($urandom_range(0, ARENA_BYTES));
        end
        else
            w.req_type = REQ_CLEAR;
        return w;
    endfunction

    // Send one request word. Enter and leave at a falling edge; hold the word
    // until the edge that takes it, then record it with the tracker.
    task automatic send_word(input req_word_t w);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        tracker.note_request(w);
        @(negedge clk);
    endtask

    // Write the capacity register once every owed response is back.
    task automatic write_capacity(input logic [OFS_W-1:0] value);
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_capacity(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [OFS_W-1:0] caps [PHASES];
        int               p;
        int               n;
        caps = '{17'h1FFFF, 17'd0, 17'd1000, 17'd65535, 17'd0, 17'd65536, 17'd70000};
        caps[4] = OFS_W'($urandom_range(256, ARENA_BYTES));

        // hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words under the reset capacity.
        send_word(make_word(REQ_PUSH, 0, 8, 0, 0));           // zero size
        send_word(make_word(REQ_PUSH, 16, 0, 0, 0));          // alignment zero
        send_word(make_word(REQ_PUSH, 16, 3, 0, 0));          // not a power of two
        send_word(make_word(REQ_PUSH, 16, 257, 0, 0));        // above 256
        send_word(make_word(REQ_PUSH, 16, 511, 0, 0));        // all ones
        send_word(make_word(REQ_PUSH, 65536, 1, 0, 0));       // out of memory on empty arena
        send_word(make_word(REQ_PUSH, 1, 1, 0, 0));           // smallest push, shift of one
        send_word(make_word(REQ_PUSH, 100, 256, 0, 0));       // widest alignment
        send_word(make_word(REQ_PUSH, 65536, 256, 0, 0));     // out of memory
        send_word(make_word(REQ_POP, 0, 0, 9, 0));            // not the latest
        send_word(make_word(REQ_POP, 0, 0, 0, 0));            // handle zero
        send_word(make_word(REQ_POP, 0, 0, 65537, 0));        // just past the arena
        send_word(make_word(REQ_POP, 0, 0, 17'h1FFFF, 0));    // largest handle
        send_word(make_word(REQ_POP, 0, 0, 256, 0));          // pop latest
        send_word(make_word(REQ_POP, 0, 0, 9, 0));            // pop down to empty
        send_word(make_word(REQ_PUSH, 64, 8, 0, 0));
        send_word(make_word(REQ_MARK, 0, 0, 0, 40));          // used drops below last size
        send_word(make_word(REQ_POP, 0, 0, 16, 0));           // rejected: used below last
        send_word(make_word(REQ_CLEAR, 0, 0, 0, 0));          // clear keeps last size
        send_word(make_word(REQ_MARK, 0, 0, 0, 248));
        send_word(make_word(REQ_PUSH, 32, 256, 0, 0));        // shift of 256, stored as zero
        send_word(make_word(REQ_POP, 0, 0, 512, 0));
        send_word(make_word(REQ_MARK, 0, 0, 0, 17'h1FFFF));   // largest marker
        send_word(make_word(REQ_PUSH, 1, 1, 0, 0));           // out of memory past the limit
        send_word(make_word(REQ_CLEAR, 0, 0, 0, 0));

        // Random phases, one capacity setting each; one phase runs without idling.
        for (p = 0; p < PHASES; p++)
        begin
            write_capacity(caps[p]);
            calm = (p == 5);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_word(next_request());
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // drain, then let the pipeline settle before the verdict
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
